// ----- rtl/pcgsd_pkg.sv -----
package pcgsd_pkg;

	localparam int unsigned FuncW   = 2;
	localparam int unsigned IndexW  = 24;
	localparam int unsigned StreamW = 7;
	localparam int unsigned CountW  = 25;
	localparam int unsigned RankW   = 16;
	localparam int unsigned WordW   = 32;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned InDataW = 64;

	localparam logic [63:0] LCG_MULT     = 64'd6364136223846793005;
	localparam logic [63:0] SM_GOLDEN    = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MIX1      = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MIX2      = 64'h94d049bb133111eb;
	localparam logic [63:0] STATE_OFFSET = 64'h853c49e6748fea9b;
	localparam logic [63:0] INC_OFFSET   = 64'hda3e39cb94b95bdb;
	// offset and golden ratio folded into one constant per seed half
	localparam logic [63:0] SEED_STATE   = STATE_OFFSET + SM_GOLDEN;
	localparam logic [63:0] SEED_INC     = INC_OFFSET + SM_GOLDEN;

	typedef enum logic [FuncW-1:0] {
		FN_DRAW   = 2'd0,
		FN_RESEED = 2'd1,
		FN_INIT   = 2'd2
	} func_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ELEMENT_COUNT = 1'd0,
		REG_NODE_RANK     = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_EMIT,
		ST_KEY,
		ST_MIXA,
		ST_MIXB
	} fsm_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] addend;
	} mul_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} mul_rsp_t;

	function automatic logic [63:0] premix1(input logic [63:0] v);
		return v ^ (v >> 30);
	endfunction

	function automatic logic [63:0] premix2(input logic [63:0] v);
		return v ^ (v >> 27);
	endfunction

	function automatic logic [63:0] postmix(input logic [63:0] v);
		return v ^ (v >> 31);
	endfunction

	// XSH-RR output permutation of the old state
	function automatic logic [WordW-1:0] xsh_rr(input logic [63:0] p);
		logic [63:0] x;
		logic [WordW-1:0] xs;
		logic [2*WordW-1:0] dbl;
		x   = (p >> 18) ^ p;
		xs  = x[58:27];
		dbl = {xs, xs} >> p[63:59];
		return dbl[WordW-1:0];
	endfunction

endpackage

// ----- rtl/pcg32_generator_with_pair_seeding_core.sv -----
// Draw: the word leaves on m_tdata once the LCG multiply is done and the output register is free.
// Reseed: one key multiply and four mixing multiplies; init: no output.
// Draws and reseeds share the one 64-bit multiplier, which handles one multiply at a time.
// A finished word waits in the output register while the next input word is taken.
// Reset (arst_n low, asynchronous) loads the default state and increment,
// element_count = 1, node_rank = 0, and empties the output register.
module pcg32_generator_with_pair_seeding_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// func[1:0], first_index[25:2], second_index[49:26], stream_number[56:50], zero pad
	input  logic [pcgsd_pkg::InDataW-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// random_word[31:0]
	output logic [pcgsd_pkg::WordW-1:0]        m_tdata,
	input  logic                               wr_en,
	input  logic [pcgsd_pkg::CfgIdxW-1:0]      wr_index,
	input  logic [pcgsd_pkg::CountW-1:0]       wr_data
);
	import pcgsd_pkg::*;

	// unpacked input fields
	func_t               func;
	logic [IndexW-1:0]   first_index, second_index, lo, hi;
	logic [StreamW-1:0]  stream_number;
	logic                accept;

	// generator state and configuration
	logic [63:0]         state_q, inc_q, key_q;
	logic [CountW-1:0]   element_count_q;
	logic [RankW-1:0]    node_rank_q;
	logic [RankW+StreamW-1:0] seed;

	// sequencer
	fsm_t                fsm_q, fsm_d;
	logic                half_q;
	logic                out_free;
	logic [63:0]         mix_fin;

	// output register
	logic                m_valid_q;
	logic [WordW-1:0]    word_q, m_data_q;

	mul_req_t            mreq;
	mul_rsp_t            mrsp;

	assign func          = func_t'(s_tdata[1:0]);
	assign first_index   = s_tdata[25:2];
	assign second_index  = s_tdata[49:26];
	assign stream_number = s_tdata[56:50];

	assign s_tready = (fsm_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// order the pair so the key is symmetric
	assign lo      = (first_index < second_index) ? first_index : second_index;
	assign hi      = (first_index < second_index) ? second_index : first_index;
	assign seed    = {node_rank_q, stream_number};
	assign mix_fin = postmix(mrsp.result);

	pcgsd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// next state
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FN_DRAW:   fsm_d = ST_DRAW;
						FN_RESEED: fsm_d = ST_KEY;
						default:   fsm_d = ST_IDLE;
					endcase
				end
			end
			ST_DRAW: if (mrsp.done) fsm_d = ST_EMIT;
			ST_EMIT: if (out_free) fsm_d = ST_IDLE;
			ST_KEY:  if (mrsp.done) fsm_d = ST_MIXA;
			ST_MIXA: if (mrsp.done) fsm_d = ST_MIXB;
			ST_MIXB: if (mrsp.done) fsm_d = half_q ? ST_IDLE : ST_MIXA;
			default: fsm_d = ST_IDLE;
		endcase
	end

	// multiplier requests
	always_comb begin
		mreq = '0;
		unique case (fsm_q)
			ST_IDLE: begin
				if (accept && func == FN_DRAW) begin
					// advance the LCG; the low increment bit is forced to one
					mreq.start  = 1'b1;
					mreq.a      = state_q;
					mreq.b      = LCG_MULT;
					mreq.addend = inc_q | 64'd1;
				end else if (accept && func == FN_RESEED) begin
					mreq.start  = 1'b1;
					mreq.a      = {{(64-IndexW){1'b0}}, lo};
					mreq.b      = {{(64-CountW){1'b0}}, element_count_q};
					mreq.addend = {{(64-IndexW){1'b0}}, hi};
				end
			end
			ST_KEY: begin
				if (mrsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = premix1(mrsp.result + SEED_STATE);
					mreq.b     = SM_MIX1;
				end
			end
			ST_MIXA: begin
				if (mrsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = premix2(mrsp.result);
					mreq.b     = SM_MIX2;
				end
			end
			ST_MIXB: begin
				// second pass mixes the increment half from the held key
				if (mrsp.done && !half_q) begin
					mreq.start = 1'b1;
					mreq.a     = premix1(key_q + SEED_INC);
					mreq.b     = SM_MIX1;
				end
			end
			default: mreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q           <= ST_IDLE;
			half_q          <= 1'b0;
			state_q         <= STATE_OFFSET;
			inc_q           <= INC_OFFSET;
			element_count_q <= CountW'(1);
			node_rank_q     <= '0;
			m_valid_q       <= 1'b0;
		end else begin
			fsm_q <= fsm_d;

			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_ELEMENT_COUNT: element_count_q <= wr_data;
					REG_NODE_RANK:     node_rank_q     <= wr_data[RankW-1:0];
					default:           ;
				endcase
			end

			if (accept && func == FN_INIT) begin
				state_q <= STATE_OFFSET + {{(64-RankW-StreamW){1'b0}}, seed};
				inc_q   <= INC_OFFSET + {{(63-RankW-StreamW){1'b0}}, seed, 1'b0};
			end

			if (fsm_q == ST_DRAW && mrsp.done)
				state_q <= mrsp.result;

			if (fsm_q == ST_MIXB && mrsp.done) begin
				if (half_q)
					inc_q <= mix_fin;
				else
					state_q <= mix_fin;
				half_q <= !half_q;
			end

			// load the next word when the register frees, else drop it once taken
			if (fsm_q == ST_EMIT && out_free)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && func == FN_DRAW)
			word_q <= xsh_rr(state_q);
		if (fsm_q == ST_KEY && mrsp.done)
			key_q <= mrsp.result;
		if (fsm_q == ST_EMIT && out_free)
			m_data_q <= word_q;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// the shared multiplier is never restarted mid-operation
	assert property (@(posedge clk) disable iff (!arst_n) !(mreq.start && mrsp.busy))
		else $error("multiplier started while busy");

	// a multiply result only arrives while the sequencer waits for one
	assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> (fsm_q == ST_DRAW || fsm_q == ST_KEY || fsm_q == ST_MIXA ||
			fsm_q == ST_MIXB))
		else $error("multiplier result with no consumer");

	// the increment half is only in flight during mixing
	assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (fsm_q == ST_MIXA || fsm_q == ST_MIXB))
		else $error("mix half flag left set");

	// a draw always starts the multiplier and moves to the draw state
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FN_DRAW) |-> mreq.start ##1 (fsm_q == ST_DRAW))
		else $error("draw not started");

	// an emitted word never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == ST_EMIT && m_valid_q && !m_tready) |=> $stable(m_data_q))
		else $error("output word overwritten");

endmodule

// ----- rtl/pcgsd_mul.sv -----
module pcgsd_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  pcgsd_pkg::mul_req_t req,
	output pcgsd_pkg::mul_rsp_t rsp
);
	import pcgsd_pkg::*;

	// low 64 bits of a*b+addend from three 32x32 partial products
	logic [63:0] a_q, b_q, add_q, acc_q, prod_q;
	logic [1:0]  step_q;
	logic        busy_q, done_q;
	logic [31:0] x, y;
	logic [63:0] prod_d;

	always_comb begin
		x = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		y = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	end

	assign prod_d = x * y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= !req.start && busy_q && (step_q == 2'd3);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			add_q <= req.addend;
		end else if (busy_q) begin
			prod_q <= prod_d;
			case (step_q)
				2'd0:    ;
				2'd1:    acc_q <= add_q + prod_q;
				default: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			endcase
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule
